FILE: src/nscv_pkg.sv
// Package for the NMEA sentence checksum verifier.
// Holds the tracker phase type, the sentence head table and hex helpers.
// No dependencies.
package nscv_pkg;

  localparam int HeadCount = 4;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] END_CHAR  = 8'h00;

  // Tracker phase: waiting for head, summing, after star, after first digit, done
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SUM   = 3'd1,
    PH_STAR  = 3'd2,
    PH_DIGIT = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  // Status word from one tracker to the top level
  typedef struct packed {
    logic fail_now;   // checksum digits rejected or mismatched on this word
    logic end_fail;   // tracker would fail if the buffer ended now
  } trk_status_t;

  // Sentence heads, first character in the top byte
  localparam logic [HeadCount-1:0][47:0] HEAD_TEXT = {
    48'h244750524D43,   // $GPRMC
    48'h244750474741,   // $GPGGA
    48'h244750475341,   // $GPGSA
    48'h244750565447    // $GPVTG
  };

  // XOR of the five head characters after the dollar sign
  function automatic logic [7:0] head_xor(input logic [47:0] head);
    logic [7:0] x;
    x = 8'h00;
    for (int k = 0; k < 5; k++) begin
      x = x ^ head[8*k +: 8];
    end
    return x;
  endfunction

  // Hex digit value in the low four bits; bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

FILE: src/nscv_tracker.sv
// One sentence tracker: sums the sentence after its head and checks the
// hex checksum that follows the star. Depends on nscv_pkg.
module nscv_tracker
  import nscv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,       // nonzero word accepted
  input  logic        clear,      // end-of-buffer word accepted
  input  logic [7:0]  cur_byte,
  input  logic        head_hit,   // head completes with this word
  input  logic [7:0]  head_sum,
  output trk_status_t status
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic [4:0]  hex;
  logic [7:0]  check_val;
  logic        fail_now;

  assign hex = hex_value(cur_byte);

  // Checksum value: two digits when the second is hex, else first alone
  assign check_val = hex[4] ? {4'h0, digit_r} : {digit_r, hex[3:0]};

  // Next state of the tracker
  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    digit_nxt = digit_r;
    fail_now  = 1'b0;
    if (clear) begin
      phase_nxt = PH_IDLE;
      xor_nxt   = 8'h00;
      digit_nxt = 4'h0;
    end else if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (head_hit) begin
            phase_nxt = PH_SUM;
            xor_nxt   = head_sum;
          end
        end
        PH_SUM: begin
          if (cur_byte == STAR_CHAR) begin
            phase_nxt = PH_STAR;
          end else begin
            xor_nxt = xor_r ^ cur_byte;
          end
        end
        PH_STAR: begin
          if (hex[4]) begin
            fail_now  = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            digit_nxt = hex[3:0];
            phase_nxt = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          fail_now  = (check_val != xor_r);
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Status toward the verdict
  always_comb begin
    status.fail_now = fail_now;
    status.end_fail = (phase_r == PH_SUM) || (phase_r == PH_STAR) ||
                      ((phase_r == PH_DIGIT) && ({4'h0, digit_r} != xor_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      xor_r   <= 8'h00;
      digit_r <= 4'h0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

FILE: src/nmea_sentence_checksum_verify.sv
// Channel  | Ports                          | Moves
// input    | in_valid in_ready in_text_byte | one text byte per word
// result   | out_valid out_ready out_buffer_valid | one verdict per buffer
//
// A new word is accepted every cycle unless a verdict waits and out_ready is low.
// The verdict for a buffer appears in the output register in the cycle after the
// zero byte is accepted. Input is held off only while a verdict waits and
// out_ready is low. Synchronous active-low reset clears all trackers.
// Top level of the NMEA sentence checksum verifier. Depends on nscv_pkg and
// nscv_tracker.
module nmea_sentence_checksum_verify
  import nscv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_buffer_valid
);

  logic [39:0]    recent_r, recent_nxt;
  logic           fail_r, fail_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           verdict_r, verdict_nxt;
  logic           accept, is_end;
  logic [47:0]    window;
  trk_status_t    status [HeadCount];
  logic [HeadCount-1:0] fail_now_v, end_fail_v;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_end   = (in_text_byte == END_CHAR);
  assign window   = {recent_r, in_text_byte};

  // One tracker per sentence head
  for (genvar t = 0; t < HeadCount; t++) begin : g_trk
    nscv_tracker u_trk (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (accept && !is_end),
      .clear    (accept && is_end),
      .cur_byte (in_text_byte),
      .head_hit (window == HEAD_TEXT[t]),
      .head_sum (head_xor(HEAD_TEXT[t])),
      .status   (status[t])
    );
    assign fail_now_v[t] = status[t].fail_now;
    assign end_fail_v[t] = status[t].end_fail;
  end

  // Advance the byte window and failure flag, load the verdict on end of buffer
  always_comb begin
    recent_nxt    = recent_r;
    fail_nxt      = fail_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (is_end) begin
        recent_nxt    = 40'h0;
        fail_nxt      = 1'b0;
        verdict_nxt   = !(fail_r || (|end_fail_v));
        out_valid_nxt = 1'b1;
      end else begin
        recent_nxt = window[39:0];
        fail_nxt   = fail_r || (|fail_now_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= 40'h0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      recent_r    <= recent_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Verdict payload, no reset needed
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_buffer_valid = verdict_r;

`ifndef SYNTH
  // A verdict appears only after an end-of-buffer word
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept && is_end))
    else $error("verdict without end of buffer");

  // The byte window is empty after an end-of-buffer word
  a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_end) |=> (recent_r == 40'h0) && !fail_r)
    else $error("state not cleared at end of buffer");

  // A waiting verdict is never dropped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(verdict_r))
    else $error("verdict lost while stalled");

  // An empty output register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked with empty output");
`endif

endmodule

FILE: tb/nmea_sentence_checksum_verify_tb.sv
// Testbench for nmea_sentence_checksum_verify: streams text buffers, predicts each verdict,
// and compares it with the verdict the block returns.
// Depends on nscv_pkg and the nmea_sentence_checksum_verify RTL.
module nmea_sentence_checksum_verify_tb
  import nscv_pkg::*;
;

  localparam int CYCLE_LIMIT = 100000;
  localparam int WORD_TARGET = 1600;
  localparam int IDLE_PCT    = 18;

  // Sentence heads, first character in the top byte; index 0 is $GPVTG
  localparam logic [3:0][47:0] SENTENCE_HEAD = {"$GPRMC", "$GPGGA", "$GPGSA", "$GPVTG"};

  localparam logic [7:0] CR_CHAR = 8'h0D;
  localparam logic [7:0] LF_CHAR = 8'h0A;

  // Checksum tail shapes for generated sentences
  localparam int TAIL_GOOD_UP   = 0;
  localparam int TAIL_GOOD_LOW  = 1;
  localparam int TAIL_ONE_DIGIT = 2;
  localparam int TAIL_WRONG     = 3;
  localparam int TAIL_NO_STAR   = 4;
  localparam int TAIL_BARE_STAR = 5;
  localparam int TAIL_BAD_HEX   = 6;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_buffer_valid;

  bit         calm = 1'b0;
  int         sent_words = 0;
  int         cycle_count = 0;
  logic [7:0] text_q[$];

  // Value of a hex character in the low nibble; bit 4 set for anything else
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      return {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return 8'("0") + 8'(n);
    end
    return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] head_sum_of(input logic [47:0] h);
    return h[39:32] ^ h[31:24] ^ h[23:16] ^ h[15:8] ^ h[7:0];
  endfunction

  // Tracks the sentence checksums of the current buffer and holds the verdicts owed
  class verdict_board;
    bit         verdict_q[$];
    int         errors;
    logic [39:0] recent;
    phase_t     phase [4];
    logic [7:0] sum [4];
    logic [3:0] lead_digit [4];
    bit         sticky_fail;

    function new();
      errors = 0;
      clear_trackers();
    endfunction

    function void clear_trackers();
      recent = '0;
      sticky_fail = 1'b0;
      for (int t = 0; t < 4; t++) begin
        phase[t] = PH_IDLE;
        sum[t] = 8'h00;
        lead_digit[t] = 4'h0;
      end
    endfunction

    // Advance every tracker by one accepted word; a zero word closes the buffer
    function void note_word(input logic [7:0] b);
      logic [47:0] window;
      logic [4:0]  d;
      logic [7:0]  value;
      bit          fail;
      if (b == END_CHAR) begin
        fail = sticky_fail;
        for (int t = 0; t < 4; t++) begin
          case (phase[t])
            PH_SUM, PH_STAR: fail = 1'b1;
            PH_DIGIT: if ({4'h0, lead_digit[t]} != sum[t]) fail = 1'b1;
            default: ;
          endcase
        end
        verdict_q.push_back(!fail);
        clear_trackers();
        return;
      end
      window = {recent, b};
      d = hex_digit_value(b);
      for (int t = 0; t < 4; t++) begin
        case (phase[t])
          PH_IDLE: begin
            if (window == SENTENCE_HEAD[t]) begin
              phase[t] = PH_SUM;
              sum[t] = head_sum_of(SENTENCE_HEAD[t]);
            end
          end
          PH_SUM: begin
            if (b == STAR_CHAR) phase[t] = PH_STAR;
            else sum[t] = sum[t] ^ b;
          end
          PH_STAR: begin
            if (d[4]) begin
              sticky_fail = 1'b1;
              phase[t] = PH_DONE;
            end else begin
              lead_digit[t] = d[3:0];
              phase[t] = PH_DIGIT;
            end
          end
          PH_DIGIT: begin
            value = d[4] ? {4'h0, lead_digit[t]} : {lead_digit[t], d[3:0]};
            if (value != sum[t]) sticky_fail = 1'b1;
            phase[t] = PH_DONE;
          end
          default: ;
        endcase
      end
      recent = window[39:0];
    endfunction

    function void check_verdict(input bit actual);
      bit want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict: expected none, actual %0b", $time, actual);
        return;
      end
      want = verdict_q.pop_front();
      if (want != actual) begin
        errors++;
        $display("%0t: verdict mismatch: expected %0b, actual %0b", $time, want, actual);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void finish_check();
      if (verdict_q.size() != 0) begin
        errors += verdict_q.size();
        $display("%0t: %0d verdicts missing: expected %0b, actual none",
                 $time, verdict_q.size(), verdict_q[0]);
      end
    endfunction
  endclass

  verdict_board board = new();

  nmea_sentence_checksum_verify dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_buffer_valid (out_buffer_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side at random, except in the calm stretch
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check every accepted verdict word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_verdict(out_buffer_valid);
    end
  end

  // Offer one word, idling first at random, and hold it until accepted
  task automatic send_word(input logic [7:0] b);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(b);
    sent_words++;
    calm = (sent_words >= 600 && sent_words < 900);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_word(text_q[i]);
    text_q.delete();
  endtask

  // Hold off the sender until every owed verdict has come back
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Append one sentence: head, random body, then a checksum tail of the given shape
  task automatic add_sentence(input int t, input int tail, input int max_body);
    logic [7:0] x;
    logic [7:0] c;
    logic [4:0] d;
    logic [3:0] pick;
    int         n;
    bit         embed;
    bit         lower;
    for (int k = 5; k >= 0; k--) text_q.push_back(SENTENCE_HEAD[t][8*k +: 8]);
    x = head_sum_of(SENTENCE_HEAD[t]);
    n = $urandom_range(0, max_body);
    embed = (max_body > 0) && ($urandom_range(0, 11) == 0);
    lower = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      // drop a second head mid-body now and then
      if (embed && i == n / 2) begin
        for (int k = 5; k >= 0; k--) begin
          c = SENTENCE_HEAD[$urandom_range(0, 3)][8*k +: 8];
          text_q.push_back(c);
          x = x ^ c;
        end
      end
      c = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(32, 126))
                                       : 8'($urandom_range(1, 255));
      if (c == STAR_CHAR) c = ",";
      text_q.push_back(c);
      x = x ^ c;
    end
    case (tail)
      TAIL_GOOD_UP, TAIL_GOOD_LOW: begin
        text_q.push_back(STAR_CHAR);
        text_q.push_back(hex_char(x[7:4], tail == TAIL_GOOD_LOW));
        text_q.push_back(hex_char(x[3:0], tail == TAIL_GOOD_LOW));
      end
      TAIL_ONE_DIGIT: begin
        // pad the body so the sum fits one digit
        pick = 4'($urandom_range(0, 15));
        if (x[7:4] != 4'h0) begin
          c = x ^ {4'h0, pick};
          if (c != STAR_CHAR) begin
            text_q.push_back(c);
            x = {4'h0, pick};
          end
        end
        text_q.push_back(STAR_CHAR);
        text_q.push_back(hex_char(x[3:0], lower));
      end
      TAIL_WRONG: begin
        x = x ^ 8'($urandom_range(1, 255));
        text_q.push_back(STAR_CHAR);
        text_q.push_back(hex_char(x[7:4], lower));
        text_q.push_back(hex_char(x[3:0], lower));
      end
      TAIL_BARE_STAR: text_q.push_back(STAR_CHAR);
      TAIL_BAD_HEX: begin
        text_q.push_back(STAR_CHAR);
        do begin
          c = 8'($urandom_range(1, 255));
          d = hex_digit_value(c);
        end while (!d[4]);
        text_q.push_back(c);
      end
      default: ;
    endcase
    if (max_body > 0) begin
      case ($urandom_range(0, 2))
        1: begin
          text_q.push_back(CR_CHAR);
          text_q.push_back(LF_CHAR);
        end
        2: text_q.push_back(",");
        default: ;
      endcase
    end
  endtask

  function automatic int pick_tail();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return TAIL_GOOD_UP;
    if (r < 50) return TAIL_GOOD_LOW;
    if (r < 62) return TAIL_ONE_DIGIT;
    if (r < 74) return TAIL_WRONG;
    if (r < 82) return TAIL_NO_STAR;
    if (r < 90) return TAIL_BARE_STAR;
    return TAIL_BAD_HEX;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty buffer, clean sentence, end right after star, non-hex after star
    text_q.push_back(END_CHAR);
    add_sentence(0, TAIL_GOOD_UP, 0);
    text_q.push_back(END_CHAR);
    add_sentence(2, TAIL_BARE_STAR, 0);
    text_q.push_back(END_CHAR);
    add_sentence(3, TAIL_BAD_HEX, 0);
    text_q.push_back(END_CHAR);
    send_text();
    drain_wait();

    // Random buffers: mostly sentences, some raw noise
    while (sent_words < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 24)) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(32, 126)));
        end
        repeat ($urandom_range(0, 4)) add_sentence($urandom_range(0, 3), pick_tail(), 10);
      end
      text_q.push_back(END_CHAR);
      send_text();
      if ($urandom_range(0, 9) == 0) drain_wait();
    end

    // Drain and settle
    drain_wait();
    repeat (4) @(posedge clk);
    board.finish_check();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
